### design/lzr_pkg.sv
// lzr_pkg: shared types and constants of the LZ/RLE byte encoder.
// No dependencies; every other design file imports it.
package lzr_pkg;

  localparam int unsigned WINDOW_SIZE_DEF = 256;
  localparam int unsigned MAX_MATCH_DEF   = 255;
  localparam int unsigned BUF_AW          = 9;    // history 256 + lookahead 255 fit in 512
  localparam int unsigned BUF_DEPTH       = 1 << BUF_AW;
  localparam int unsigned RUN_CAP         = 127;
  localparam int unsigned BLOCK_MAX       = 128;
  localparam int unsigned THR_BASE        = 2;
  localparam int unsigned THR_GROW        = 3;

  typedef enum logic [1:0] {
    TK_LITERAL = 2'd0,
    TK_RUN     = 2'd1,
    TK_MATCH   = 2'd2,
    TK_DONE    = 2'd3
  } kind_e;

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [0:0] action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] token_kind;
    logic [7:0] token_byte;
    logic [7:0] token_length;
    logic [7:0] match_distance_code;
    logic [6:0] literal_position;
  } out_item_t;

  typedef struct packed {
    cmd_e       kind;
    logic [7:0] data_byte;
  } cmd_t;

endpackage

### design/lzr_in_if.sv
// lzr_in_if: valid/ready channel carrying one input item.
// Depends on lzr_pkg.
interface lzr_in_if;
  import lzr_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/lzr_out_if.sv
// lzr_out_if: valid/ready channel carrying one result token.
// Depends on lzr_pkg.
interface lzr_out_if;
  import lzr_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/lz_rle_byte_encoder.sv
// Greedy LZ77/RLE byte encoder. A push that does not fill the lookahead is stored without a decision.
// A decision first scans the run, then tries each distance in turn; every compare reads the
// buffer memory through its registered read ports.
// Items are handled one decision at a time; a two-entry queue and an output register
// decouple both sides. Reset clears control state at once; buffer contents stay undefined.
module lz_rle_byte_encoder #(
  parameter int unsigned WINDOW_SIZE = lzr_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned MAX_MATCH   = lzr_pkg::MAX_MATCH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lzr_in_if.sink    in_i,
  lzr_out_if.source out_o
);
  import lzr_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  lzr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  lzr_back #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .MAX_MATCH   (MAX_MATCH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .out_o       (out_o)
  );

endmodule

### design/lzr_front.sv
// lzr_front: accepts input items, classifies them as push or flush commands
// and holds them in a two-entry queue. Depends on lzr_pkg and lzr_in_if.
module lzr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  lzr_in_if.sink          in_i,
  output logic            cmd_valid_o,
  output lzr_pkg::cmd_t   cmd_o,
  input  logic            cmd_ready_i
);
  import lzr_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cmd_t       cmd_new;

  // classify the incoming item
  always_comb begin
    cmd_new.kind      = (in_i.data.action == 1'b1) ? CMD_FLUSH : CMD_PUSH;
    cmd_new.data_byte = in_i.data.data_byte;
  end

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = entry_q[rd_ptr_q];

  // store commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### design/lzr_back.sv
// lzr_back: history/lookahead buffer, sequential run and match search,
// token decision and output register. Depends on lzr_pkg and lzr_out_if.
module lzr_back #(
  parameter int unsigned WINDOW_SIZE = lzr_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned MAX_MATCH   = lzr_pkg::MAX_MATCH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  lzr_pkg::cmd_t   cmd_i,
  output logic            cmd_ready_o,
  lzr_out_if.source       out_o
);
  import lzr_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_FRONT   = 10'b0000000010,
    ST_FRONT_W = 10'b0000000100,
    ST_RUN_RD  = 10'b0000001000,
    ST_RUN_CMP = 10'b0000010000,
    ST_MT_INIT = 10'b0000100000,
    ST_MT_RD   = 10'b0001000000,
    ST_MT_CMP  = 10'b0010000000,
    ST_MT_END  = 10'b0100000000,
    ST_DECIDE  = 10'b1000000000
  } state_e;

  localparam logic [8:0] WIN9 = 9'(WINDOW_SIZE);
  localparam logic [8:0] MAX9 = 9'(MAX_MATCH);

  // combined buffer: history sits below head, lookahead from head on
  logic [7:0]        mem_q [BUF_DEPTH];
  logic [7:0]        rd_a_q, rd_b_q;
  logic [BUF_AW-1:0] addr_a, addr_b, wr_addr;
  logic [7:0]        wr_data;
  logic              wr_en;

  state_e            state_q, state_d;
  logic [BUF_AW-1:0] head_q, head_d;
  logic [8:0]        count_q, count_d;
  logic [8:0]        fill_q, fill_d;
  logic [7:0]        olc_q, olc_d;
  logic [7:0]        front_q, front_d;
  logic [8:0]        run_q, run_d;
  logic [8:0]        lim_q, lim_d;
  logic [8:0]        len_q, len_d;
  logic [8:0]        dist_q, dist_d;
  logic [8:0]        best_q, best_d;
  logic [7:0]        bcode_q, bcode_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              out_free;
  logic              can_grow;
  logic [8:0]        thr;
  logic              take_match, take_run;
  logic [8:0]        run_cap, consume_n;
  logic [9:0]        fill_sum;
  logic [8:0]        new_best;

  assign out_free    = !out_valid_q || out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // decision terms
  always_comb begin
    can_grow   = (olc_q != 8'd0) && (olc_q < 8'(BLOCK_MAX));
    thr        = can_grow ? 9'(THR_GROW) : 9'(THR_BASE);
    take_match = (best_q > run_q + 9'd1) && (best_q > thr);
    take_run   = (run_q >= thr);
    run_cap    = (run_q > 9'(RUN_CAP)) ? 9'(RUN_CAP) : run_q;
    new_best   = (len_q > best_q) ? len_q : best_q;
  end

  // memory write port and two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_a_q <= mem_q[addr_a];
    rd_b_q <= mem_q[addr_b];
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    fill_d      = fill_q;
    olc_d       = olc_q;
    front_d     = front_q;
    run_d       = run_q;
    lim_d       = lim_q;
    len_d       = len_q;
    dist_d      = dist_q;
    best_d      = best_q;
    bcode_d     = bcode_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    cmd_ready_o = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = head_q + count_q;
    wr_data     = cmd_i.data_byte;
    addr_a      = head_q;
    addr_b      = head_q;
    consume_n   = 9'd1;
    fill_sum    = 10'd0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == CMD_PUSH) begin
            cmd_ready_o = 1'b1;
            wr_en       = 1'b1;
            count_d     = count_q + 9'd1;
            if (count_q + 9'd1 >= MAX9) state_d = ST_FRONT;
          end else if (count_q != 9'd0) begin
            cmd_ready_o = 1'b1;
            state_d     = ST_FRONT;
          end else if (out_free) begin
            // drained stream: report done and close it
            cmd_ready_o       = 1'b1;
            out_valid_d       = 1'b1;
            out_d             = '0;
            out_d.token_kind  = TK_DONE;
            fill_d            = 9'd0;
            olc_d             = 8'd0;
          end
        end
      end
      ST_FRONT: begin
        addr_a  = head_q;
        state_d = ST_FRONT_W;
      end
      ST_FRONT_W: begin
        front_d = rd_a_q;
        run_d   = 9'd1;
        state_d = ST_RUN_RD;
      end
      ST_RUN_RD: begin
        addr_a = head_q + run_q;
        state_d = (run_q < count_q) ? ST_RUN_CMP : ST_MT_INIT;
      end
      ST_RUN_CMP: begin
        if (rd_a_q == front_q) begin
          run_d   = run_q + 9'd1;
          state_d = ST_RUN_RD;
        end else begin
          state_d = ST_MT_INIT;
        end
      end
      ST_MT_INIT: begin
        lim_d   = (count_q < MAX9) ? count_q : MAX9;
        dist_d  = 9'd1;
        len_d   = 9'd0;
        best_d  = 9'd0;
        bcode_d = 8'd0;
        state_d = (fill_q == 9'd0) ? ST_DECIDE : ST_MT_RD;
      end
      ST_MT_RD: begin
        addr_a  = head_q + len_q;
        addr_b  = head_q + len_q - dist_q;
        state_d = (len_q == lim_q) ? ST_MT_END : ST_MT_CMP;
      end
      ST_MT_CMP: begin
        if (rd_a_q == rd_b_q) begin
          len_d   = len_q + 9'd1;
          state_d = ST_MT_RD;
        end else begin
          state_d = ST_MT_END;
        end
      end
      ST_MT_END: begin
        if (len_q > best_q) begin
          best_d  = len_q;
          bcode_d = 8'(dist_q - 9'd1);
        end
        // stop once the match cannot grow or distances run out
        if (new_best == lim_q || dist_q == fill_q) begin
          state_d = ST_DECIDE;
        end else begin
          dist_d  = dist_q + 9'd1;
          len_d   = 9'd0;
          state_d = ST_MT_RD;
        end
      end
      ST_DECIDE: begin
        if (take_match)    consume_n = best_q;
        else if (take_run) consume_n = run_cap;
        else               consume_n = 9'd1;
        fill_sum = {1'b0, fill_q} + {1'b0, consume_n};
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          if (take_match) begin
            out_d.token_kind          = TK_MATCH;
            out_d.token_length        = best_q[7:0];
            out_d.match_distance_code = bcode_q;
            olc_d                     = 8'd0;
          end else if (take_run) begin
            out_d.token_kind   = TK_RUN;
            out_d.token_byte   = front_q;
            out_d.token_length = run_cap[7:0];
            olc_d              = 8'd0;
          end else begin
            out_d.token_kind = TK_LITERAL;
            out_d.token_byte = front_q;
            if (can_grow) begin
              out_d.literal_position = olc_q[6:0];
              olc_d                  = olc_q + 8'd1;
            end else begin
              olc_d = 8'd1;
            end
          end
          head_d  = head_q + consume_n;
          count_d = count_q - consume_n;
          fill_d  = (fill_sum > {1'b0, WIN9}) ? WIN9 : fill_sum[8:0];
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= 9'd0;
      fill_q      <= 9'd0;
      olc_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      fill_q      <= fill_d;
      olc_q       <= olc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hold search and output payload
  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    run_q   <= run_d;
    lim_q   <= lim_d;
    len_q   <= len_d;
    dist_q  <= dist_d;
    best_q  <= best_d;
    bcode_q <= bcode_d;
    out_q   <= out_d;
  end

endmodule
